/* hdl/assert_macros.svh */
// Assertion macros for the deframer RTL, used by the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst_n is high.
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define WSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/wsd_pkg.sv */
// Package with shared types, constants and functions of the WebSocket deframer.
`timescale 1ns / 1ps
package wsd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [31:0] MaxLenReset = 32'd15360;

  typedef enum logic [2:0] {
    ACT_DELIVER    = 3'd0,
    ACT_PONG       = 3'd1,
    ACT_IGNORE     = 3'd2,
    ACT_CLOSE_NORM = 3'd3,
    ACT_CLOSE_PROT = 3'd4,
    ACT_CLOSE_BIG  = 3'd5
  } action_t;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    action_t    action;
  } result_t;

  function automatic action_t action_of(input logic [3:0] op);
    action_t a;
    unique case (op)
      OP_CONT, OP_TEXT, OP_BINARY: a = ACT_DELIVER;
      OP_PING:                     a = ACT_PONG;
      OP_PONG:                     a = ACT_IGNORE;
      OP_CLOSE:                    a = ACT_CLOSE_NORM;
      default:                     a = ACT_CLOSE_PROT;
    endcase
    return a;
  endfunction

endpackage

/* hdl/wsd_cfg_regs.sv */
// Configuration register bank with an APB-style slave port.
`timescale 1ns / 1ps
module wsd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wsd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [wsd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [wsd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [31:0]                   max_len
);
  import wsd_pkg::*;

  logic [31:0] max_len_r;
  logic [31:0] max_len_nxt;
  logic        sel_max_len;

  // Register index is the word address, bit 2 upward.
  assign sel_max_len = (cfg_paddr[CfgAddrW-1] == 1'b0);

  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_max_len) begin
      max_len_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign cfg_prdata = sel_max_len ? max_len_r : '0;
  assign cfg_pready = 1'b1;
  assign max_len    = max_len_r;

endmodule

/* hdl/wsd_frame_parser.sv */
// Frame header parser, length check and payload unmasking, one byte per cycle in which fire is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_frame_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic [31:0]      max_len,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hbl_r, hbl_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic        masked_r, masked_nxt;
  logic        upper_r, upper_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [7:0]  key_r [4];

  logic [3:0]  hbl_dec;
  logic [31:0] len_new;
  logic        len_done;
  logic [32:0] idx_inc;
  logic        frame_end;
  logic [1:0]  key_widx;

  assign hbl_dec  = hbl_r - 4'd1;
  assign idx_inc  = {1'b0, idx_r} + 33'd1;
  assign key_widx = 2'd0 - hbl_r[1:0];

  always_comb begin
    phase_nxt  = phase_r;
    hbl_nxt    = hbl_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    masked_nxt = masked_r;
    upper_nxt  = upper_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    len_new    = len_r;
    len_done   = 1'b0;
    frame_end  = 1'b0;
    res_valid  = 1'b0;
    res.data     = 8'd0;
    res.has_data = 1'b0;
    res.opcode   = opcode_r;
    res.fin      = fin_r;
    res.last     = 1'b1;
    res.action   = action_of(opcode_r);

    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt    = rx_byte[7];
        opcode_nxt = rx_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = rx_byte[7];
        upper_nxt  = 1'b0;
        len_nxt    = 32'd0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          hbl_nxt   = 4'd2;
          phase_nxt = PH_EXT;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          hbl_nxt   = 4'd8;
          phase_nxt = PH_EXT;
        end else begin
          len_new  = {25'd0, rx_byte[6:0]};
          len_nxt  = len_new;
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        if (hbl_r > 4'd4) begin
          if (rx_byte != 8'd0) begin
            upper_nxt = 1'b1;
          end
        end else begin
          len_new = {len_r[23:0], rx_byte};
        end
        len_nxt  = len_new;
        hbl_nxt  = hbl_dec;
        len_done = (hbl_dec == 4'd0);
      end
      PH_MASK: begin
        hbl_nxt = hbl_dec;
        if (hbl_dec == 4'd0) begin
          if (len_r == 32'd0) begin
            res_valid = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        frame_end    = (idx_inc >= {1'b0, len_r});
        idx_nxt      = idx_inc[31:0];
        res_valid    = 1'b1;
        res.has_data = 1'b1;
        res.data     = masked_r ? (rx_byte ^ key_r[idx_r[1:0]]) : rx_byte;
        res.last     = frame_end;
        if (frame_end) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // Length complete: size check first, then mask key, payload or empty frame.
    if (len_done) begin
      if (upper_nxt || (len_new > max_len)) begin
        res_valid  = 1'b1;
        res.action = ACT_CLOSE_BIG;
        phase_nxt  = PH_HALT;
      end else begin
        idx_nxt = 32'd0;
        if (masked_nxt) begin
          hbl_nxt   = 4'd4;
          phase_nxt = PH_MASK;
        end else if (len_new == 32'd0) begin
          res_valid = 1'b1;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      hbl_r    <= 4'd0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      masked_r <= 1'b0;
      upper_r  <= 1'b0;
      len_r    <= 32'd0;
      idx_r    <= 32'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      hbl_r    <= hbl_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      masked_r <= masked_nxt;
      upper_r  <= upper_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (phase_r == PH_MASK)) begin
      key_r[key_widx] <= rx_byte;
    end
  end

  `WSD_ASSERT(a_empty_is_last, (res_valid && !res.has_data) |-> res.last,
              "Result without data must end the frame.")
  `WSD_ASSERT(a_big_halts, (fire && res_valid && (res.action == ACT_CLOSE_BIG))
              |=> (phase_r == PH_HALT), "Too-big close must halt the parser.")
  `WSD_ASSERT(a_halt_silent, (phase_r == PH_HALT) |-> !res_valid,
              "Halted parser must not produce results.")

endmodule

/* hdl/websocket_frame_deframer_unit.sv */
// Top level of the WebSocket frame deframer: input register, parser, output register.
`timescale 1ns / 1ps
// The in_ channel takes one received byte per word (in_tdata[7:0]). The out_
// channel gives one word per payload byte, or a single word without data for
// an empty frame or for a too-big close. out_tlast marks the word that ends a
// frame, out_tuser carries has_data, the frame opcode and the action code.
// The cfg_ port holds max_payload_len at byte address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A byte accepted on in_ sits in the input register and is parsed from there; its
// word, if any, is captured in the output register and offered on out_. One byte
// is taken every cycle as long as the output side keeps up; the parser state
// register is the only loop.
// When out_tready is low a pending word holds, the input register keeps one
// more byte and in_tready then drops until the output drains.
// Synchronous reset clears the parser to wait for a first header byte, empties
// both registers and restores max_payload_len to 15360. After a too-big close
// the block swallows all further bytes until the next reset.
module websocket_frame_deframer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [7:0] data, [8] fin, [15:9] zero
  output logic [7:0]                    out_tuser,  // [0] has_data, [4:1] opcode, [7:5] action
  output logic                          out_tlast,  // last
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wsd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [wsd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [wsd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import wsd_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  logic        advance;
  logic        res_valid;
  result_t     res;
  logic [31:0] max_len;

  wsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  wsd_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .rx_byte   (in_byte_r),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.fin, out_res_r.data};
  assign out_tuser  = {out_res_r.action, out_res_r.opcode, out_res_r.has_data};
  assign out_tlast  = out_res_r.last;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the WebSocket frame deframer with a built-in frame predictor.
module tb;
  import wsd_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned RandomBytes = 350;
  localparam logic [31:0] MaxLenAtReset = 32'd15360;
  localparam logic [CfgAddrW-1:0] AddrMaxLen = '0;
  localparam logic [3:0] OpReserved = 4'd3;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_MASK, PH_PAYLOAD, PH_HALT
  } parse_phase_t;

  typedef enum int {ENC_LEN7, ENC_LEN16, ENC_LEN64} len_enc_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;  // [7:0] data, [8] fin, [15:9] zero
  logic [7:0]          out_tuser;  // [0] has_data, [4:1] opcode, [7:5] action
  logic                out_tlast;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  parse_phase_t ph;
  logic [3:0]   hdr_left;
  logic [3:0]   f_op;
  logic         f_fin;
  logic         f_masked;
  logic         len_hi_nz;
  logic [31:0]  plen;
  logic [31:0]  pidx;
  logic [31:0]  max_len;
  logic [7:0]   mask_key [4];
  result_t      expected_words [$];

  int err_cnt = 0;
  int bytes_sent = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  websocket_frame_deframer_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic action_t action_for(input logic [3:0] op);
    case (op)
      OP_CONT, OP_TEXT, OP_BINARY: return ACT_DELIVER;
      OP_PING:                     return ACT_PONG;
      OP_PONG:                     return ACT_IGNORE;
      OP_CLOSE:                    return ACT_CLOSE_NORM;
      default:                     return ACT_CLOSE_PROT;
    endcase
  endfunction

  function automatic void push_word(input logic [7:0] d, input logic has, input logic last,
                                    input action_t act);
    result_t w;
    w.data = d;
    w.has_data = has;
    w.opcode = f_op;
    w.fin = f_fin;
    w.last = last;
    w.action = act;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void parser_clear();
    ph = PH_HDR0;
    hdr_left = '0;
    f_op = '0;
    f_fin = 1'b0;
    f_masked = 1'b0;
    len_hi_nz = 1'b0;
    plen = '0;
    pidx = '0;
    max_len = MaxLenAtReset;
    foreach (mask_key[i]) mask_key[i] = '0;
  endfunction

  // The length is checked as soon as it is complete, before any mask byte.
  function automatic void length_complete();
    if (len_hi_nz || plen > max_len) begin
      push_word(8'h00, 1'b0, 1'b1, ACT_CLOSE_BIG);
      ph = PH_HALT;
    end else begin
      pidx = '0;
      if (f_masked) begin
        hdr_left = 4'd4;
        ph = PH_MASK;
      end else if (plen == 0) begin
        push_word(8'h00, 1'b0, 1'b1, action_for(f_op));
        ph = PH_HDR0;
      end else begin
        ph = PH_PAYLOAD;
      end
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] d;
    logic       done;
    case (ph)
      PH_HDR0: begin
        f_fin = b[7];
        f_op = b[3:0];
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        f_masked = b[7];
        len_hi_nz = 1'b0;
        plen = '0;
        if (b[6:0] == LEN_EXT16) begin
          hdr_left = 4'd2;
          ph = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          hdr_left = 4'd8;
          ph = PH_EXT;
        end else begin
          plen = {25'd0, b[6:0]};
          length_complete();
        end
      end
      PH_EXT: begin
        if (hdr_left > 4'd4) begin
          if (b != 8'h00) len_hi_nz = 1'b1;
        end else begin
          plen = {plen[23:0], b};
        end
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_complete();
      end
      PH_MASK: begin
        mask_key[2'(4'd4 - hdr_left)] = b;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if (plen == 0) begin
            push_word(8'h00, 1'b0, 1'b1, action_for(f_op));
            ph = PH_HDR0;
          end else begin
            ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        d = f_masked ? (b ^ mask_key[pidx[1:0]]) : b;
        pidx = pidx + 1;
        done = (pidx >= plen);
        push_word(d, 1'b1, done, action_for(f_op));
        if (done) ph = PH_HDR0;
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : word_checker
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata %h tuser %h tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        w = expected_words.pop_front();
        check_field("data", 32'(w.data), 32'(out_tdata[7:0]));
        check_field("fin", 32'(w.fin), 32'(out_tdata[8]));
        check_field("tdata padding", 32'd0, 32'(out_tdata[15:9]));
        check_field("has_data", 32'(w.has_data), 32'(out_tuser[0]));
        check_field("opcode", 32'(w.opcode), 32'(out_tuser[4:1]));
        check_field("action", 32'(w.action), 32'(out_tuser[7:5]));
        check_field("last", 32'(w.last), 32'(out_tlast));
      end
    end
  end

  initial begin : receiver_pacing
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AddrMaxLen;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(output logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= AddrMaxLen;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    v = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_max_len(input logic [31:0] v);
    logic [31:0] rd;
    wait_idle();
    cfg_write(v);
    max_len = v;
    cfg_read(rd);
    check_field("max_payload_len readback", v, rd);
  endtask

  task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input logic [63:0] len, input len_enc_t enc);
    send_byte({fin, rsv, op});
    case (enc)
      ENC_LEN7: send_byte({masked, len[6:0]});
      ENC_LEN16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input logic [31:0] len, input len_enc_t enc);
    send_header(fin, rsv, op, masked, {32'd0, len}, enc);
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (len) send_byte(8'($urandom));
  endtask

  function automatic logic [3:0] pick_opcode();
    logic [3:0] ops [6];
    ops = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    if ($urandom_range(0, 9) < 7) return ops[3'($urandom_range(0, 5))];
    return 4'($urandom);
  endfunction

  // Most frames are short; a few use the extended lengths, up to 300 bytes.
  task automatic send_random_frame(input logic [31:0] cap);
    logic [31:0] len;
    int          r;
    len_enc_t    enc;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 75) len = $urandom_range(1, 20);
    else if (r < 92) len = $urandom_range(21, 125);
    else len = $urandom_range(126, 300);
    if (len > cap) len = cap;
    r = $urandom_range(0, 9);
    if (len > 125) enc = (r < 5) ? ENC_LEN16 : ENC_LEN64;
    else enc = (r < 8) ? ENC_LEN7 : ((r == 8) ? ENC_LEN16 : ENC_LEN64);
    send_frame(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom), len, enc);
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    cfg_read(rd);
    check_field("max_payload_len after reset", MaxLenAtReset, rd);
  endtask

  task automatic test_directed_frames();
    send_header(1'b1, 3'b000, OP_TEXT, 1'b1, 64'd1, ENC_LEN7);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'hFF);
    send_header(1'b0, 3'b111, OP_PONG, 1'b0, 64'd0, ENC_LEN7);
    send_header(1'b0, 3'b000, OpReserved, 1'b0, 64'd2, ENC_LEN7);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(1'b1, 3'b000, OP_CLOSE, 1'b1, 64'd0, ENC_LEN7);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    send_header(1'b1, 3'b000, OP_PING, 1'b1, 64'd2, ENC_LEN16);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h04);
    send_byte(8'h08);
    send_byte(8'hFE);
    send_byte(8'hFD);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random_frame(max_len);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_length_limits();
    set_max_len(32'd0);
    repeat (6)
      send_frame(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom), 32'd0,
                 len_enc_t'($urandom_range(0, 2)));
    set_max_len(32'hFFFF_FFFE);
    repeat (3) send_random_frame(max_len);
    set_max_len(32'd3);
    repeat (3)
      send_frame(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom), 32'd3,
                 len_enc_t'($urandom_range(0, 2)));
    repeat (10) send_random_frame(max_len);
    set_max_len($urandom_range(20, 400));
    repeat (6) send_random_frame(max_len);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering bytes.
  task automatic test_output_stall();
    int stop_at;
    idle_on = 1'b0;
    hold_cycles = 200;
    stop_at = bytes_sent + 60;
    while (bytes_sent < stop_at) send_random_frame(20);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // The block halts for good after a too-big close, so this runs last.
  task automatic test_too_big_halt();
    logic [31:0] lim;
    logic [31:0] upper;
    idle_on = 1'b0;
    case ($urandom_range(0, 3))
      0: begin
        lim = $urandom_range(0, 124);
        set_max_len(lim);
        repeat (3) send_random_frame(lim);
        send_header(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom),
                    {32'd0, lim + 1}, ENC_LEN7);
      end
      1: begin
        lim = $urandom_range(125, 2000);
        set_max_len(lim);
        repeat (3) send_random_frame(lim);
        send_header(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom),
                    {32'd0, lim + 1}, ENC_LEN16);
      end
      2: begin
        set_max_len(32'hFFFF_FFFE);
        repeat (3) send_random_frame(max_len);
        upper = $urandom;
        if (upper == 0) upper = 32'd1;
        send_header(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom),
                    {upper, 32'($urandom_range(0, 20))}, ENC_LEN64);
      end
      default: begin
        set_max_len(32'hFFFF_FFFE);
        repeat (3) send_random_frame(max_len);
        send_header(1'($urandom), 3'($urandom), pick_opcode(), 1'($urandom),
                    64'h0000_0000_FFFF_FFFF, ENC_LEN64);
      end
    endcase
    repeat (24) send_byte(8'($urandom));
  endtask

  initial begin
    parser_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value();
    test_directed_frames();
    test_random_traffic();
    test_length_limits();
    test_output_stall();
    test_too_big_halt();
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
